// ===== rtl/core/irmc_pkg.sv =====
// ----------------------------------------------------------------------------
// irmc_pkg
// Shared codes and types of the frame rotate / mirror / crop engine.
// ----------------------------------------------------------------------------
package irmc_pkg;

  localparam int MODE_W    = 3;
  localparam int DIM_REG_W = 9;
  localparam int CFG_IDX_W = 3;
  localparam int PORT_CH_W = 8;

  localparam logic [MODE_W-1:0] MODE_ROT_CCW = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROT_CW  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIR_H   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIR_V   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESIZE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd4;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 9'd256;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EXEC,
    ST_READ
  } state_t;

  typedef struct packed {
    logic black;
    logic last;
  } xf_flags_t;

endpackage

// ===== rtl/core/image_rotate_mirror_crop.sv =====
// ----------------------------------------------------------------------------
// image_rotate_mirror_crop
// Frame transform engine: rotate, mirror, crop or pad one stored RGB frame.
// ----------------------------------------------------------------------------
// A load transaction passes through the CALC and EXEC states and then back
// to idle, and so does a fetch that comes before the frame is fully loaded;
// a fetch that returns a pixel goes on through the READ state, where its
// result strobes on out_valid for exactly one cycle. No new transaction is
// accepted until the block is back in idle. The sequence follows from the
// frame store (MAX_DIM*MAX_DIM entries of three CHANNEL_BITS channels, a
// write port and a registered read port) behind a registered address stage
// with two multipliers. The receiver cannot stall: each result must be
// taken in its strobe cycle. Loads past the frame size are dropped; a
// fetch before the frame is fully loaded returns no result. The frame
// store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module image_rotate_mirror_crop #(
  parameter int MAX_DIM      = 256,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_kind,
  input  logic [irmc_pkg::PORT_CH_W-1:0]      in_red_in,
  input  logic [irmc_pkg::PORT_CH_W-1:0]      in_green_in,
  input  logic [irmc_pkg::PORT_CH_W-1:0]      in_blue_in,
  output logic                                out_valid,
  output logic [irmc_pkg::PORT_CH_W-1:0]      out_red_out,
  output logic [irmc_pkg::PORT_CH_W-1:0]      out_green_out,
  output logic [irmc_pkg::PORT_CH_W-1:0]      out_blue_out,
  output logic                                out_last_pixel,
  input  logic                                cfg_we,
  input  logic [irmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irmc_pkg::DIM_REG_W-1:0]      cfg_wdata
);
  import irmc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int LC_W   = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int CB     = CHANNEL_BITS;
  localparam int PIX_W  = 3 * CHANNEL_BITS;

  state_t                 state_r, state_nxt;
  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [DIM_REG_W-1:0]   src_w_r, src_w_nxt, src_h_r, src_h_nxt;
  logic [DIM_REG_W-1:0]   dst_w_r, dst_w_nxt, dst_h_r, dst_h_nxt;
  logic [LC_W-1:0]        load_count_r, load_count_nxt;
  logic [CNT_W-1:0]       out_col_r, out_col_nxt, out_row_r, out_row_nxt;

  logic                   kind_r;
  logic [PIX_W-1:0]       pix_r;
  logic [PIX_W-1:0]       rd_data_r;
  logic [PIX_W-1:0]       frame_mem [DEPTH];

  logic [LC_W-1:0]        total_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [CNT_W-1:0]       col_nxt_r, row_nxt_r;
  xf_flags_t              flags_r;

  logic                   accept, loaded, mem_we, fetch_go;

  irmc_xform #(
    .MAX_DIM (MAX_DIM)
  ) u_xform (
    .clk        (clk),
    .mode       (mode_r),
    .src_width  (src_w_r),
    .src_height (src_h_r),
    .dst_width  (dst_w_r),
    .dst_height (dst_h_r),
    .out_col    (out_col_r),
    .out_row    (out_row_r),
    .total_r    (total_r),
    .addr_r     (addr_r),
    .col_nxt_r  (col_nxt_r),
    .row_nxt_r  (row_nxt_r),
    .flags_r    (flags_r)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign loaded   = (load_count_r >= total_r);
  assign mem_we   = (state_r == ST_EXEC) && (kind_r == KIND_LOAD) && !loaded;
  assign fetch_go = (state_r == ST_EXEC) && (kind_r == KIND_FETCH) && loaded;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CALC;
      end
      ST_CALC: state_nxt = ST_EXEC;
      ST_EXEC: begin
        state_nxt = fetch_go ? ST_READ : ST_IDLE;
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    src_w_nxt      = src_w_r;
    src_h_nxt      = src_h_r;
    dst_w_nxt      = dst_w_r;
    dst_h_nxt      = dst_h_r;
    load_count_nxt = load_count_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;

    // advance counters
    if (mem_we) begin
      load_count_nxt = load_count_r + LC_W'(1);
    end
    if (fetch_go) begin
      out_col_nxt = col_nxt_r;
      out_row_nxt = row_nxt_r;
      if (flags_r.last) load_count_nxt = '0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: begin
          mode_nxt    = MODE_W'(cfg_wdata);
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        REG_SRC_WIDTH: begin
          src_w_nxt   = cfg_wdata;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        REG_SRC_HEIGHT: begin
          src_h_nxt   = cfg_wdata;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        REG_DST_WIDTH: begin
          dst_w_nxt   = cfg_wdata;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        REG_DST_HEIGHT: begin
          dst_h_nxt   = cfg_wdata;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_ROT_CCW;
      src_w_r      <= DIM_RESET;
      src_h_r      <= DIM_RESET;
      dst_w_r      <= DIM_RESET;
      dst_h_r      <= DIM_RESET;
      load_count_r <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
    end else begin
      mode_r       <= mode_nxt;
      src_w_r      <= src_w_nxt;
      src_h_r      <= src_h_nxt;
      dst_w_r      <= dst_w_nxt;
      dst_h_r      <= dst_h_nxt;
      load_count_r <= load_count_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
    end
  end

  // hold the transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      pix_r  <= {CB'(in_red_in), CB'(in_green_in), CB'(in_blue_in)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[load_count_r[ADDR_W-1:0]] <= pix_r;
    end
    rd_data_r <= frame_mem[addr_r];
  end

  assign out_valid      = (state_r == ST_READ);
  assign out_last_pixel = out_valid && flags_r.last;
  assign out_red_out    = flags_r.black ? '0 : PORT_CH_W'(rd_data_r[3*CB-1:2*CB]);
  assign out_green_out  = flags_r.black ? '0 : PORT_CH_W'(rd_data_r[2*CB-1:CB]);
  assign out_blue_out   = flags_r.black ? '0 : PORT_CH_W'(rd_data_r[CB-1:0]);

endmodule

// ===== rtl/core/irmc_xform.sv =====
// ----------------------------------------------------------------------------
// irmc_xform
// Maps the output position to a frame store address, flags padding and the
// final pixel, steps the output position and computes the frame size.
// ----------------------------------------------------------------------------
module irmc_xform #(
  parameter int MAX_DIM = 256
) (
  input  logic                                        clk,
  input  logic [irmc_pkg::MODE_W-1:0]                 mode,
  input  logic [irmc_pkg::DIM_REG_W-1:0]              src_width,
  input  logic [irmc_pkg::DIM_REG_W-1:0]              src_height,
  input  logic [irmc_pkg::DIM_REG_W-1:0]              dst_width,
  input  logic [irmc_pkg::DIM_REG_W-1:0]              dst_height,
  input  logic [$clog2(MAX_DIM)-1:0]                  out_col,
  input  logic [$clog2(MAX_DIM)-1:0]                  out_row,
  output logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0]        total_r,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]          addr_r,
  output logic [$clog2(MAX_DIM)-1:0]                  col_nxt_r,
  output logic [$clog2(MAX_DIM)-1:0]                  row_nxt_r,
  output irmc_pkg::xf_flags_t                         flags_r
);
  import irmc_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int LC_W   = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int VW     = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
  localparam int PW     = 2 * DIM_W;

  function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_REG_W-1:0] v);
    logic [VW-1:0] ve;
    ve = VW'(v);
    if (ve == '0) begin
      dim_of = DIM_W'(1);
    end else if (ve > VW'(MAX_DIM)) begin
      dim_of = DIM_W'(MAX_DIM);
    end else begin
      dim_of = DIM_W'(ve);
    end
  endfunction

  logic [DIM_W-1:0]  w, h, ow, oh, col_e, row_e, sr, sc;
  logic [PW-1:0]     prod, tot;
  logic              black, last, wrap;
  logic [LC_W-1:0]   total_nxt;
  logic [ADDR_W-1:0] addr_nxt;
  logic [CNT_W-1:0]  col_nxt, row_nxt;
  xf_flags_t         flags_nxt;

  always_comb begin
    w     = dim_of(src_width);
    h     = dim_of(src_height);
    col_e = DIM_W'(out_col);
    row_e = DIM_W'(out_row);
    ow    = w;
    oh    = h;
    sr    = '0;
    sc    = '0;
    black = 1'b0;
    unique case (mode)
      MODE_ROT_CCW: begin
        ow = h;
        oh = w;
        sr = col_e;
        sc = w - DIM_W'(1) - row_e;
      end
      MODE_ROT_CW: begin
        ow = h;
        oh = w;
        sr = h - DIM_W'(1) - col_e;
        sc = row_e;
      end
      MODE_MIR_H: begin
        sr = row_e;
        sc = w - DIM_W'(1) - col_e;
      end
      MODE_MIR_V: begin
        sr = h - DIM_W'(1) - row_e;
        sc = col_e;
      end
      default: begin
        ow = dim_of(dst_width);
        oh = dim_of(dst_height);
        if (row_e < h && col_e < w) begin
          sr = row_e;
          sc = col_e;
        end else begin
          black = 1'b1;
        end
      end
    endcase

    prod      = sr * w;
    tot       = w * h;
    addr_nxt  = ADDR_W'(prod + PW'(sc));
    total_nxt = LC_W'(tot);

    last = (row_e + DIM_W'(1) == oh) && (col_e + DIM_W'(1) == ow);
    wrap = (col_e + DIM_W'(1) >= ow);
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (wrap) begin
      col_nxt = '0;
      row_nxt = CNT_W'(row_e + DIM_W'(1));
    end else begin
      col_nxt = CNT_W'(col_e + DIM_W'(1));
      row_nxt = out_row;
    end

    flags_nxt.black = black;
    flags_nxt.last  = last;
  end

  always_ff @(posedge clk) begin
    total_r   <= total_nxt;
    addr_r    <= addr_nxt;
    col_nxt_r <= col_nxt;
    row_nxt_r <= row_nxt;
    flags_r   <= flags_nxt;
  end

endmodule

// ===== rtl/core/irmc_checker.sv =====
// ----------------------------------------------------------------------------
// irmc_checker
// Port-level checks of the frame transform engine, bound to the top level.
// ----------------------------------------------------------------------------
module irmc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last_pixel
);

  // result strobes only while a transaction is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accept did not raise busy");

  // one fetch gives one single-cycle result
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_pixel |-> out_valid)
    else $error("last pixel flag without result");

endmodule

bind image_rotate_mirror_crop irmc_checker u_irmc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_last_pixel (out_last_pixel)
);
